// ===== design/i2cmbs_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master bit sequencer - shared package
// Beat types, command and status codes, and the control store of the
// bit sequencer: one control word for each step of the bus program.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cmbs_pkg;

  localparam int unsigned CMD_W        = 3;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned REQ_W        = 10;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned BYTE_COUNT_W = 11;
  localparam int unsigned BIT_IDX_W    = 4;

  // Bit position at the start of a byte, the position left after its last bit, and that of its last bit
  localparam logic [BIT_IDX_W-1:0] BIT_FIRST = 4'd7;
  localparam logic [BIT_IDX_W-1:0] BIT_SPENT = 4'd15;
  localparam logic [BIT_IDX_W-1:0] BIT_LAST  = 4'd0;

  // Commands carried by an input beat
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_CLEAR   = 3'd1,
    CMD_PUSH    = 3'd2,
    CMD_SEND    = 3'd3,
    CMD_REQUEST = 3'd4
  } cmd_e;

  // Transfer status
  typedef enum logic [STATUS_W-1:0] {
    ST_PENDING = 2'd0,
    ST_SUCCESS = 2'd1,
    ST_NACK    = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  // Program steps; the step counter holds one of these
  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START0   = 4'd1,
    PH_START1   = 4'd2,
    PH_START2   = 4'd3,
    PH_START3   = 4'd4,
    PH_PUSH     = 4'd5,
    PH_ACKWAIT0 = 4'd6,
    PH_ACKWAIT1 = 4'd7,
    PH_ACKCHECK = 4'd8,
    PH_READ     = 4'd9,
    PH_ACKSEND  = 4'd10,
    PH_ACKSENT  = 4'd11,
    PH_STOP0    = 4'd12,
    PH_STOP1    = 4'd13,
    PH_STOP2    = 4'd14
  } phase_e;

  // Clock line operation
  typedef enum logic [1:0] {
    SCL_HOLD,
    SCL_CLR,
    SCL_SET,
    SCL_TOG
  } scl_op_e;

  // Data line level operation
  typedef enum logic [2:0] {
    SDA_HOLD,
    SDA_CLR,
    SDA_SET,
    SDA_TXBIT,
    SDA_ACKBIT
  } sda_op_e;

  // Data line drive operation
  typedef enum logic [2:0] {
    OE_HOLD,
    OE_CLR,
    OE_SET,
    OE_SET_WA,
    OE_SET_WC
  } oe_op_e;

  // Datapath action
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_INIT_IDX,
    ACT_TX,
    ACT_RX,
    ACT_STATUS,
    ACT_DONE
  } act_e;

  // Branch condition
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_TX_END,
    COND_SCL_HIGH,
    COND_ACK_CHECK,
    COND_RX_END,
    COND_ACK_SEND
  } cond_e;

  // Branch outcome
  typedef enum logic [1:0] {
    WAY_STAY,
    WAY_A,
    WAY_B,
    WAY_C
  } way_e;

  // One control word
  typedef struct packed {
    scl_op_e scl_op;
    sda_op_e sda_op;
    oe_op_e  oe_op;
    act_e    act;
    cond_e   cond;
    phase_e  nxt_a;
    phase_e  nxt_b;
    phase_e  nxt_c;
  } ucode_t;

  // Input beat
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic              sda_in;
    logic [BYTE_W-1:0] data_byte;
    logic [REQ_W-1:0]  request_count;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic                    scl_level;
    logic                    sda_level;
    logic                    sda_drive;
    logic                    busy_res;
    logic                    done_res;
    logic [STATUS_W-1:0]     status;
    logic                    rx_valid;
    logic [BYTE_W-1:0]       rx_byte;
    logic [BYTE_COUNT_W-1:0] byte_count;
    logic                    push_accepted;
  } out_item_t;

  // Control store
  function automatic ucode_t ucode_rom(phase_e ph);
    ucode_t w;
    w = '{SCL_HOLD, SDA_HOLD, OE_HOLD, ACT_NONE, COND_ALWAYS, PH_IDLE, PH_IDLE, PH_IDLE};
    case (ph)
      PH_START0:   w = '{SCL_HOLD, SDA_CLR, OE_HOLD, ACT_NONE, COND_ALWAYS,
                         PH_START1, PH_IDLE, PH_IDLE};
      PH_START1:   w = '{SCL_HOLD, SDA_HOLD, OE_HOLD, ACT_NONE, COND_ALWAYS,
                         PH_START2, PH_IDLE, PH_IDLE};
      PH_START2:   w = '{SCL_CLR, SDA_HOLD, OE_HOLD, ACT_NONE, COND_ALWAYS,
                         PH_START3, PH_IDLE, PH_IDLE};
      PH_START3:   w = '{SCL_SET, SDA_HOLD, OE_HOLD, ACT_INIT_IDX, COND_ALWAYS,
                         PH_PUSH, PH_IDLE, PH_IDLE};
      PH_PUSH:     w = '{SCL_TOG, SDA_TXBIT, OE_HOLD, ACT_TX, COND_TX_END,
                         PH_ACKWAIT0, PH_IDLE, PH_IDLE};
      PH_ACKWAIT0: w = '{SCL_TOG, SDA_HOLD, OE_CLR, ACT_NONE, COND_ALWAYS,
                         PH_ACKWAIT1, PH_IDLE, PH_IDLE};
      PH_ACKWAIT1: w = '{SCL_TOG, SDA_HOLD, OE_HOLD, ACT_NONE, COND_SCL_HIGH,
                         PH_ACKCHECK, PH_IDLE, PH_IDLE};
      PH_ACKCHECK: w = '{SCL_TOG, SDA_HOLD, OE_SET_WC, ACT_STATUS, COND_ACK_CHECK,
                         PH_STOP0, PH_READ, PH_PUSH};
      PH_READ:     w = '{SCL_TOG, SDA_HOLD, OE_SET_WA, ACT_RX, COND_RX_END,
                         PH_ACKSEND, PH_IDLE, PH_IDLE};
      PH_ACKSEND:  w = '{SCL_TOG, SDA_ACKBIT, OE_HOLD, ACT_STATUS, COND_ACK_SEND,
                         PH_STOP0, PH_ACKSENT, PH_IDLE};
      PH_ACKSENT:  w = '{SCL_TOG, SDA_HOLD, OE_CLR, ACT_NONE, COND_ALWAYS,
                         PH_READ, PH_IDLE, PH_IDLE};
      PH_STOP0:    w = '{SCL_SET, SDA_HOLD, OE_SET, ACT_NONE, COND_ALWAYS,
                         PH_STOP1, PH_IDLE, PH_IDLE};
      PH_STOP1:    w = '{SCL_HOLD, SDA_HOLD, OE_HOLD, ACT_NONE, COND_ALWAYS,
                         PH_STOP2, PH_IDLE, PH_IDLE};
      PH_STOP2:    w = '{SCL_HOLD, SDA_SET, OE_HOLD, ACT_DONE, COND_ALWAYS,
                         PH_IDLE, PH_IDLE, PH_IDLE};
      default:     w = '{SCL_HOLD, SDA_HOLD, OE_HOLD, ACT_NONE, COND_ALWAYS,
                         PH_IDLE, PH_IDLE, PH_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== design/i2c_master_bit_sequencer.sv =====
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Half-period tick driven I2C master: a byte store filled by push beats,
// a send program and a request program run from a control store, and one
// result beat for every input beat.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------
//  input    | in        | in_valid_i / in_stall_o | in_data_i
//  result   | out       | out_valid_o/ out_stall_i| out_data_o
//  config   | in        | cfg_we_i (no wait)      | cfg_wdata_i
//
//  Each input beat is first captured, with the store entry at the current
//  byte position fetched, and then the control word of the current step is
//  run on it. The capture register holds one beat at a time: the input
//  stalls while a beat runs. The result register parts the two sides; a
//  stalled result holds the next beat in the capture register and the input stalls behind it.
//  Reset clears control state only; the byte store needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_sequencer
  import i2cmbs_pkg::*;
#(
  parameter int unsigned BUF_DEPTH = 1024
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o,
  input  wire logic      cfg_we_i,
  input  wire logic      cfg_wdata_i
);

  localparam int unsigned AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int unsigned CW    = $clog2(BUF_DEPTH + 1);
  localparam int unsigned CMP_W = (CW > REQ_W + 1) ? CW : REQ_W + 1;

  // Handshake and control state
  logic                 exec_q;
  logic                 out_valid_q;
  logic                 in_accept;
  logic                 exec_fire;
  in_item_t             item_q;
  out_item_t            out_q, out_d;
  logic                 ignore_nack_q;

  // Sequencer state
  phase_e               phase_q, phase_d;
  logic                 rd_mode_q, rd_mode_d;
  logic [BIT_IDX_W-1:0] bit_idx_q, bit_idx_d;
  logic [CW-1:0]        byte_idx_q, byte_idx_d;
  logic [CW-1:0]        buf_len_q, buf_len_d;
  logic [REQ_W-1:0]     req_q, req_d;
  logic [BYTE_W-1:0]    rx_shift_q, rx_shift_d;
  logic                 scl_q, scl_d;
  logic                 sda_q, sda_d;
  logic                 oe_q, oe_d;
  status_e              status_q, status_d;

  // Byte store
  logic [BYTE_W-1:0]    mem [BUF_DEPTH];
  logic [BYTE_W-1:0]    rd_q;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [BYTE_W-1:0]    wr_data;

  // Step decode
  ucode_t               uc;
  way_e                 way;
  logic                 nack_abort;
  logic                 send_end;
  logic                 req_done;
  logic                 store_full;
  logic                 rx_valid;
  logic [BYTE_W-1:0]    rx_byte;
  logic                 done;
  logic                 push_ok;

  // Handshake
  assign in_stall_o  = exec_q;
  assign in_accept   = in_valid_i && !exec_q;
  assign exec_fire   = exec_q && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Capture register and result register valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exec_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        exec_q <= 1'b1;
      end else if (exec_fire) begin
        exec_q <= 1'b0;
      end
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the accepted beat and the finished result
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_data_i;
    end
    if (exec_fire) begin
      out_q <= out_d;
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ignore_nack_q <= 1'b0;
    end else if (cfg_we_i) begin
      ignore_nack_q <= cfg_wdata_i;
    end
  end

  // Byte store: fetch at capture, write whenever the captured beat's decode asks for it
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (in_accept) begin
      if (byte_idx_q < CW'(BUF_DEPTH)) begin
        rd_q <= mem[byte_idx_q[AW-1:0]];
      end else begin
        rd_q <= '0;
      end
    end
  end

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      rd_mode_q  <= 1'b0;
      bit_idx_q  <= BIT_FIRST;
      byte_idx_q <= '0;
      buf_len_q  <= '0;
      req_q      <= '0;
      rx_shift_q <= '0;
      scl_q      <= 1'b1;
      sda_q      <= 1'b1;
      oe_q       <= 1'b1;
      status_q   <= ST_PENDING;
    end else if (exec_fire) begin
      phase_q    <= phase_d;
      rd_mode_q  <= rd_mode_d;
      bit_idx_q  <= bit_idx_d;
      byte_idx_q <= byte_idx_d;
      buf_len_q  <= buf_len_d;
      req_q      <= req_d;
      rx_shift_q <= rx_shift_d;
      scl_q      <= scl_d;
      sda_q      <= sda_d;
      oe_q       <= oe_d;
      status_q   <= status_d;
    end
  end

  // Branch conditions of the current step
  always_comb begin
    uc         = ucode_rom(phase_q);
    nack_abort = item_q.sda_in && !ignore_nack_q;
    send_end   = byte_idx_q >= buf_len_q;
    req_done   = CMP_W'(byte_idx_q) >= (CMP_W'(req_q) + CMP_W'(1));
    store_full = byte_idx_q >= CW'(BUF_DEPTH);
    case (uc.cond)
      COND_ALWAYS:    way = WAY_A;
      COND_TX_END:    way = (!scl_q && bit_idx_q == BIT_SPENT) ? WAY_A : WAY_STAY;
      COND_SCL_HIGH:  way = scl_q ? WAY_A : WAY_STAY;
      COND_ACK_CHECK: begin
        if (nack_abort || (!rd_mode_q && send_end)) begin
          way = WAY_A;
        end else if (rd_mode_q) begin
          way = WAY_B;
        end else begin
          way = WAY_C;
        end
      end
      COND_RX_END:    way = (!scl_q && bit_idx_q == BIT_LAST) ? WAY_A : WAY_STAY;
      COND_ACK_SEND:  way = (req_done || store_full) ? WAY_A : WAY_B;
      default:        way = WAY_STAY;
    endcase
  end

  // Run the captured beat: next state, store write and result fields
  always_comb begin
    phase_d    = phase_q;
    rd_mode_d  = rd_mode_q;
    bit_idx_d  = bit_idx_q;
    byte_idx_d = byte_idx_q;
    buf_len_d  = buf_len_q;
    req_d      = req_q;
    rx_shift_d = rx_shift_q;
    scl_d      = scl_q;
    sda_d      = sda_q;
    oe_d       = oe_q;
    status_d   = status_q;
    wr_en      = 1'b0;
    wr_addr    = byte_idx_q[AW-1:0];
    wr_data    = rx_shift_q;
    rx_valid   = 1'b0;
    rx_byte    = '0;
    done       = 1'b0;
    push_ok    = 1'b0;

    case (cmd_e'(item_q.cmd))
      CMD_TICK: begin
        // Clock line; a missing acknowledge leaves it where it is
        case (uc.scl_op)
          SCL_CLR: scl_d = 1'b0;
          SCL_SET: scl_d = 1'b1;
          SCL_TOG: begin
            if (!(uc.cond == COND_ACK_CHECK && nack_abort)) begin
              scl_d = ~scl_q;
            end
          end
          default: scl_d = scl_q;
        endcase

        // Data line level
        case (uc.sda_op)
          SDA_CLR:    sda_d = 1'b0;
          SDA_SET:    sda_d = 1'b1;
          SDA_TXBIT: begin
            if (scl_q) begin
              sda_d = rd_q[bit_idx_q[2:0]];
            end
          end
          SDA_ACKBIT: sda_d = (way == WAY_A);
          default:    sda_d = sda_q;
        endcase

        // Data line drive
        case (uc.oe_op)
          OE_CLR:    oe_d = 1'b0;
          OE_SET:    oe_d = 1'b1;
          OE_SET_WA: begin
            if (way == WAY_A) begin
              oe_d = 1'b1;
            end
          end
          OE_SET_WC: begin
            if (way == WAY_C) begin
              oe_d = 1'b1;
            end
          end
          default:   oe_d = oe_q;
        endcase

        // Datapath action
        case (uc.act)
          ACT_INIT_IDX: begin
            bit_idx_d  = BIT_FIRST;
            byte_idx_d = '0;
          end
          ACT_TX: begin
            if (scl_q) begin
              bit_idx_d = bit_idx_q - BIT_IDX_W'(1);
            end else if (way == WAY_A) begin
              bit_idx_d  = BIT_FIRST;
              byte_idx_d = byte_idx_q + CW'(1);
            end
          end
          ACT_RX: begin
            if (!scl_q) begin
              rx_shift_d[bit_idx_q[2:0]] = item_q.sda_in;
              if (bit_idx_q == BIT_LAST) begin
                bit_idx_d  = BIT_FIRST;
                wr_en      = !store_full;
                wr_data    = rx_shift_d;
                rx_valid   = 1'b1;
                rx_byte    = rx_shift_d;
                byte_idx_d = byte_idx_q + CW'(1);
              end else begin
                bit_idx_d = bit_idx_q - BIT_IDX_W'(1);
              end
            end
          end
          ACT_STATUS: begin
            if (way == WAY_A) begin
              if (uc.cond == COND_ACK_CHECK) begin
                status_d = nack_abort ? ST_NACK : ST_SUCCESS;
              end else begin
                status_d = req_done ? ST_SUCCESS : ST_FULL;
              end
            end
          end
          ACT_DONE: done = 1'b1;
          default:  done = 1'b0;
        endcase

        // Advance the step counter
        case (way)
          WAY_A:   phase_d = uc.nxt_a;
          WAY_B:   phase_d = uc.nxt_b;
          WAY_C:   phase_d = uc.nxt_c;
          default: phase_d = phase_q;
        endcase
      end
      CMD_CLEAR: buf_len_d = '0;
      CMD_PUSH: begin
        if (buf_len_q < CW'(BUF_DEPTH)) begin
          wr_en     = 1'b1;
          wr_addr   = buf_len_q[AW-1:0];
          wr_data   = item_q.data_byte;
          buf_len_d = buf_len_q + CW'(1);
          push_ok   = 1'b1;
        end
      end
      CMD_SEND, CMD_REQUEST: begin
        if (cmd_e'(item_q.cmd) == CMD_REQUEST) begin
          req_d = item_q.request_count;
        end
        rd_mode_d = (cmd_e'(item_q.cmd) == CMD_REQUEST);
        status_d  = ST_PENDING;
        phase_d   = PH_START0;
        sda_d     = 1'b1;
        scl_d     = 1'b1;
        oe_d      = 1'b1;
      end
      default: phase_d = phase_q;
    endcase

    // Result beat shows the state after the step
    out_d.scl_level     = scl_d;
    out_d.sda_level     = sda_d;
    out_d.sda_drive     = oe_d;
    out_d.busy_res      = (phase_d != PH_IDLE);
    out_d.done_res      = done;
    out_d.status        = status_d;
    out_d.rx_valid      = rx_valid;
    out_d.rx_byte       = rx_byte;
    out_d.byte_count    = BYTE_COUNT_W'(byte_idx_d);
    out_d.push_accepted = push_ok;
  end

  // Checks
  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("input not stalled while a beat runs");

  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_fire && done) |=> (phase_q == PH_IDLE))
    else $error("stop completed but sequencer not idle");

  a_rx_only_reading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_fire && rx_valid) |-> rd_mode_q)
    else $error("received byte outside a request");

  a_byte_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_idx_q <= CW'(BUF_DEPTH))
    else $error("byte position beyond the store");

  a_bit_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bit_idx_q <= BIT_FIRST) || (bit_idx_q == BIT_SPENT))
    else $error("bit position out of range");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master bit sequencer - self-checking testbench
// A short table of directed beats pins the idle and start-up results; then
// random sessions fill and clear the byte store and run send and request
// transfers toward their stop condition. Every unpinned result beat is checked
// against a cycle-free model of the sequencer kept inside this bench.
// ----------------------------------------------------------------------------

module tb_top;
  import i2cmbs_pkg::*;

  localparam int unsigned STORE_DEPTH = 1024;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned IDLE_PCT    = 37;
  localparam int unsigned NACK_PCT    = 15;
  localparam int unsigned MAX_PRINTED = 50;

  // Command codes the block does not decode
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  typedef struct {
    in_item_t  beat;
    logic      pinned;
    out_item_t want;
  } dir_row_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_beat   = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_beat;
  logic      cfg_we    = 1'b0;
  logic      cfg_wdata = 1'b0;

  // Bench model of the sequencer state
  logic        nack_ignored;
  phase_e      seq_phase;
  logic        rd_mode;
  logic [3:0]  bit_pos;
  logic [10:0] byte_pos;
  logic [10:0] store_len;
  logic [9:0]  req_count;
  logic [7:0]  byte_mem [0:STORE_DEPTH-1];
  logic [7:0]  rx_shift_q;
  logic        scl_q;
  logic        sda_q;
  logic        oe_q;
  status_e     stat_q;

  out_item_t   pending_results [$];
  dir_row_t    dir_rows [$];
  out_item_t   at_rest;
  out_item_t   stored;
  out_item_t   started;
  out_item_t   got_res;
  out_item_t   want_res;
  int unsigned live_items  = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  logic        calm        = 1'b0;

  i2c_master_bit_sequencer #(
    .BUF_DEPTH(STORE_DEPTH)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_beat),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_beat),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: give up on a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Random back-pressure on the result side, none while calm
  always @(negedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
  end

  // Restart a transfer from the start condition
  function automatic void open_transfer(logic reading);
    stat_q    = ST_PENDING;
    seq_phase = PH_START0;
    rd_mode   = reading;
    sda_q     = 1'b1;
    scl_q     = 1'b1;
    oe_q      = 1'b1;
  endfunction

  // Advance the model by one beat and return the result it should give
  function automatic out_item_t advance_sequencer(in_item_t it);
    out_item_t   r;
    logic [7:0]  tx_byte;
    logic [10:0] ack_limit;
    logic        stop_seen;
    r         = '0;
    stop_seen = 1'b0;
    case (it.cmd)
      CMD_TICK: begin
        stop_seen = (seq_phase == PH_STOP2);
        case (seq_phase)
          PH_START0: begin
            sda_q     = 1'b0;
            seq_phase = PH_START1;
          end
          PH_START1: seq_phase = PH_START2;
          PH_START2: begin
            scl_q     = 1'b0;
            seq_phase = PH_START3;
          end
          PH_START3: begin
            scl_q     = 1'b1;
            seq_phase = PH_PUSH;
            bit_pos   = BIT_FIRST;
            byte_pos  = '0;
          end
          PH_PUSH: begin
            // shift one bit out on the high half, step the byte on the low half
            if (scl_q) begin
              tx_byte = (byte_pos < 11'(STORE_DEPTH)) ? byte_mem[byte_pos[9:0]] : 8'h00;
              sda_q   = tx_byte[bit_pos[2:0]];
              bit_pos = bit_pos - 4'd1;
            end else if (bit_pos == BIT_SPENT) begin
              bit_pos   = BIT_FIRST;
              byte_pos  = byte_pos + 11'd1;
              seq_phase = PH_ACKWAIT0;
            end
            scl_q = ~scl_q;
          end
          PH_ACKWAIT0: begin
            scl_q     = ~scl_q;
            oe_q      = 1'b0;
            seq_phase = PH_ACKWAIT1;
          end
          PH_ACKWAIT1: begin
            scl_q = ~scl_q;
            if (!scl_q) seq_phase = PH_ACKCHECK;
          end
          PH_ACKCHECK: begin
            if (it.sda_in && !nack_ignored) begin
              stat_q    = ST_NACK;
              seq_phase = PH_STOP0;
            end else begin
              if (!rd_mode) begin
                if (byte_pos >= store_len) begin
                  stat_q    = ST_SUCCESS;
                  seq_phase = PH_STOP0;
                end else begin
                  seq_phase = PH_PUSH;
                  oe_q      = 1'b1;
                end
              end else begin
                seq_phase = PH_READ;
              end
              scl_q = ~scl_q;
            end
          end
          PH_READ: begin
            // sample on the low half; a full byte is stored and presented
            if (!scl_q) begin
              rx_shift_q[bit_pos[2:0]] = it.sda_in;
              bit_pos = bit_pos - 4'd1;
              if (bit_pos == BIT_SPENT) begin
                bit_pos = BIT_FIRST;
                if (byte_pos < 11'(STORE_DEPTH)) byte_mem[byte_pos[9:0]] = rx_shift_q;
                r.rx_valid = 1'b1;
                r.rx_byte  = rx_shift_q;
                byte_pos   = byte_pos + 11'd1;
                seq_phase  = PH_ACKSEND;
                oe_q       = 1'b1;
              end
            end
            scl_q = ~scl_q;
          end
          PH_ACKSEND: begin
            ack_limit = {1'b0, req_count} + 11'd1;
            if (byte_pos >= ack_limit || byte_pos >= 11'(STORE_DEPTH)) begin
              sda_q     = 1'b1;
              stat_q    = (byte_pos >= ack_limit) ? ST_SUCCESS : ST_FULL;
              seq_phase = PH_STOP0;
            end else begin
              sda_q     = 1'b0;
              seq_phase = PH_ACKSENT;
            end
            scl_q = ~scl_q;
          end
          PH_ACKSENT: begin
            scl_q     = ~scl_q;
            seq_phase = PH_READ;
            oe_q      = 1'b0;
          end
          PH_STOP0: begin
            scl_q     = 1'b1;
            oe_q      = 1'b1;
            seq_phase = PH_STOP1;
          end
          PH_STOP1: seq_phase = PH_STOP2;
          PH_STOP2: begin
            sda_q     = 1'b1;
            seq_phase = PH_IDLE;
          end
          default: seq_phase = PH_IDLE;
        endcase
      end
      CMD_CLEAR: store_len = '0;
      CMD_PUSH: begin
        if (store_len < 11'(STORE_DEPTH)) begin
          byte_mem[store_len[9:0]] = it.data_byte;
          store_len       = store_len + 11'd1;
          r.push_accepted = 1'b1;
        end
      end
      CMD_SEND: open_transfer(1'b0);
      CMD_REQUEST: begin
        req_count = it.request_count;
        open_transfer(1'b1);
      end
      default: ;
    endcase
    r.scl_level  = scl_q;
    r.sda_level  = sda_q;
    r.sda_drive  = oe_q;
    r.busy_res   = (seq_phase != PH_IDLE);
    r.done_res   = stop_seen;
    r.status     = stat_q;
    r.byte_count = byte_pos;
    return r;
  endfunction

  // Random sender gap, none while calm
  function automatic logic in_gap();
    return !calm && ($urandom_range(99) < IDLE_PCT);
  endfunction

  function automatic in_item_t make_beat(logic [CMD_W-1:0] cmd);
    in_item_t it;
    it.cmd           = cmd;
    it.sda_in        = 1'($urandom_range(1));
    it.data_byte     = 8'($urandom_range(255));
    it.request_count = 10'($urandom_range(1023));
    return it;
  endfunction

  // Half tick; acknowledge mostly given, the rest of the data line random
  function automatic in_item_t make_tick();
    in_item_t it;
    it = make_beat(CMD_TICK);
    if (seq_phase == PH_ACKCHECK) it.sda_in = ($urandom_range(99) < NACK_PCT);
    return it;
  endfunction

  // Request with mostly short counts, now and then a long one, the largest or zero
  function automatic in_item_t make_request();
    in_item_t    it;
    int unsigned sel;
    it  = make_beat(CMD_REQUEST);
    sel = $urandom_range(9);
    if (sel < 5)       it.request_count = 10'($urandom_range(3));
    else if (sel == 8) it.request_count = '1;
    else if (sel == 9) it.request_count = '0;
    return it;
  endfunction

  // Stray beat dropped into a running transfer
  function automatic in_item_t make_noise();
    case ($urandom_range(4))
      0:       return make_beat(CMD_PUSH);
      1:       return make_beat(CMD_CLEAR);
      2:       return make_beat(CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO)));
      3:       return make_beat(CMD_SEND);
      default: return make_request();
    endcase
  endfunction

  // Offer one beat, hold it until taken, then log what it should produce
  task automatic put_beat(in_item_t it, logic pinned = 1'b0, out_item_t want = '0);
    out_item_t predicted;
    logic      counts;
    counts = !(it.cmd > CMD_REQUEST || (it.cmd == CMD_TICK && seq_phase == PH_IDLE));
    @(negedge clk);
    while (in_gap()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = advance_sequencer(it);
    pending_results.push_back(pinned ? want : predicted);
    if (counts) live_items++;
  endtask

  // Drop valid and wait for every outstanding result
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_ignore_nack(logic value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    nack_ignored = value;
  endtask

  // One random session: either a store update or a transfer
  task automatic run_session();
    int unsigned pick;
    int unsigned n;
    int unsigned budget;
    pick = $urandom_range(99);
    if (pick < 30) begin
      if ($urandom_range(9) == 0) put_beat(make_beat(CMD_TICK));
      if ($urandom_range(1)) put_beat(make_beat(CMD_CLEAR));
      n = $urandom_range(4);
      repeat (n) put_beat(make_beat(CMD_PUSH));
    end else begin
      if (pick < 62) put_beat(make_beat(CMD_SEND));
      else           put_beat(make_request());
      // run toward the stop condition, cutting long transfers short
      budget = $urandom_range(160, 30);
      while (seq_phase != PH_IDLE && budget != 0) begin
        budget--;
        if ($urandom_range(99) < 4) put_beat(make_noise());
        else                        put_beat(make_tick());
      end
    end
  endtask

  task automatic run_phase(int unsigned quota);
    int unsigned start;
    start = live_items;
    while (live_items - start < quota) run_session();
  endtask

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("mismatch at result %0d: %s", results_seen, msg);
  endtask

  task automatic compare_field(string name, logic [10:0] got, logic [10:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_res = out_beat;
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want_res = pending_results.pop_front();
        compare_field("scl_level", 11'(got_res.scl_level), 11'(want_res.scl_level));
        compare_field("sda_level", 11'(got_res.sda_level), 11'(want_res.sda_level));
        compare_field("sda_drive", 11'(got_res.sda_drive), 11'(want_res.sda_drive));
        compare_field("busy_res", 11'(got_res.busy_res), 11'(want_res.busy_res));
        compare_field("done_res", 11'(got_res.done_res), 11'(want_res.done_res));
        compare_field("status", 11'(got_res.status), 11'(want_res.status));
        compare_field("rx_valid", 11'(got_res.rx_valid), 11'(want_res.rx_valid));
        compare_field("rx_byte", 11'(got_res.rx_byte), 11'(want_res.rx_byte));
        compare_field("byte_count", got_res.byte_count, want_res.byte_count);
        compare_field("push_accepted", 11'(got_res.push_accepted),
                      11'(want_res.push_accepted));
      end
      results_seen++;
    end
  end

  function automatic in_item_t beat_of(logic [CMD_W-1:0] cmd, logic sda, logic [7:0] data,
                                       logic [9:0] count);
    in_item_t it;
    it.cmd           = cmd;
    it.sda_in        = sda;
    it.data_byte     = data;
    it.request_count = count;
    return it;
  endfunction

  function automatic void add_row(in_item_t it, logic pinned, out_item_t want);
    dir_row_t row;
    row.beat   = it;
    row.pinned = pinned;
    row.want   = want;
    dir_rows.push_back(row);
  endfunction

  // Main sequence
  initial begin
    // model state after reset
    nack_ignored = 1'b0;
    seq_phase    = PH_IDLE;
    rd_mode      = 1'b0;
    bit_pos      = BIT_FIRST;
    byte_pos     = '0;
    store_len    = '0;
    req_count    = '0;
    rx_shift_q   = '0;
    scl_q        = 1'b1;
    sda_q        = 1'b1;
    oe_q         = 1'b1;
    stat_q       = ST_PENDING;

    at_rest = '{scl_level: 1'b1, sda_level: 1'b1, sda_drive: 1'b1, busy_res: 1'b0,
                done_res: 1'b0, status: ST_PENDING, rx_valid: 1'b0, rx_byte: '0,
                byte_count: '0, push_accepted: 1'b0};
    stored  = at_rest;
    stored.push_accepted = 1'b1;
    started = at_rest;
    started.busy_res     = 1'b1;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    write_ignore_nack(1'b0);

    // Directed beats: idle ticks, spare codes, clears, pushes at the byte extremes,
    // then restarts, pushes and clears in the middle of a transfer
    add_row(beat_of(CMD_TICK, 1'b1, 8'hFF, 10'h3FF), 1'b1, at_rest);
    add_row(beat_of(CMD_SPARE_HI, 1'b1, 8'hFF, 10'h3FF), 1'b1, at_rest);
    add_row(beat_of(CMD_SPARE_LO, 1'b0, 8'h00, 10'h000), 1'b1, at_rest);
    add_row(beat_of(CMD_SPARE_LO + 3'd1, 1'b0, 8'h5A, 10'h155), 1'b1, at_rest);
    add_row(beat_of(CMD_CLEAR, 1'b0, 8'h00, 10'h000), 1'b1, at_rest);
    add_row(beat_of(CMD_PUSH, 1'b0, 8'h00, 10'h000), 1'b1, stored);
    add_row(beat_of(CMD_PUSH, 1'b1, 8'hFF, 10'h3FF), 1'b1, stored);
    add_row(beat_of(CMD_CLEAR, 1'b1, 8'hFF, 10'h3FF), 1'b1, at_rest);
    add_row(beat_of(CMD_PUSH, 1'b0, 8'hA1, 10'h000), 1'b1, stored);
    add_row(beat_of(CMD_REQUEST, 1'b0, 8'h00, 10'h3FF), 1'b1, started);
    add_row(beat_of(CMD_TICK, 1'b0, 8'h00, 10'h000), 1'b0, '0);
    add_row(beat_of(CMD_TICK, 1'b1, 8'hFF, 10'h3FF), 1'b0, '0);
    add_row(beat_of(CMD_PUSH, 1'b0, 8'h3C, 10'h000), 1'b0, '0);
    add_row(beat_of(CMD_CLEAR, 1'b0, 8'h00, 10'h000), 1'b0, '0);
    add_row(beat_of(CMD_SEND, 1'b1, 8'h00, 10'h000), 1'b0, '0);
    add_row(beat_of(CMD_TICK, 1'b1, 8'h00, 10'h000), 1'b0, '0);
    add_row(beat_of(CMD_TICK, 1'b0, 8'h00, 10'h000), 1'b0, '0);
    add_row(beat_of(CMD_TICK, 1'b1, 8'h00, 10'h000), 1'b0, '0);
    add_row(beat_of(CMD_TICK, 1'b0, 8'h00, 10'h000), 1'b0, '0);
    add_row(beat_of(CMD_TICK, 1'b0, 8'h00, 10'h000), 1'b0, '0);
    add_row(beat_of(CMD_REQUEST, 1'b0, 8'h00, 10'h000), 1'b0, '0);
    add_row(beat_of(CMD_TICK, 1'b0, 8'h00, 10'h000), 1'b0, '0);
    add_row(beat_of(CMD_TICK, 1'b1, 8'h00, 10'h000), 1'b0, '0);
    foreach (dir_rows[k]) put_beat(dir_rows[k].beat, dir_rows[k].pinned, dir_rows[k].want);
    settle();

    // Random transfers with a missing acknowledge ignored
    write_ignore_nack(1'b1);
    run_phase(200);
    settle();

    // Fill the store past full, then abort on a missing acknowledge
    write_ignore_nack(1'b0);
    put_beat(make_beat(CMD_CLEAR));
    repeat (STORE_DEPTH + 2) put_beat(make_beat(CMD_PUSH));
    run_phase(200);
    settle();

    // Back-to-back stretch with no sender gaps or result back-pressure, then random again
    write_ignore_nack(1'b1);
    calm = 1'b1;
    run_phase(200);
    calm = 1'b0;
    run_phase(100);
    settle();

    write_ignore_nack(1'b0);
    run_phase(200);
    settle();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
